[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Every check is clocked on clk_i and
// is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property check.
`define BDD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication check.
`define BDD_ASSERT_IMP(lbl, ante, cons, msg) \
  `BDD_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[rtl/bdd_pkg.sv]
package bdd_pkg;

  // Width of every tick limit register.
  localparam int unsigned TICK_W = 16;

  // Register map, indexed by word address.
  localparam logic [2:0] REG_ACTIVE_LEVEL  = 3'd0;
  localparam logic [2:0] REG_HOLD_MODE     = 3'd1;
  localparam logic [2:0] REG_CLICK_ON_REL  = 3'd2;
  localparam logic [2:0] REG_DEBOUNCE      = 3'd3;
  localparam logic [2:0] REG_REPEAT_DELAY  = 3'd4;
  localparam logic [2:0] REG_REPEAT_PERIOD = 3'd5;
  localparam logic [2:0] REG_FAST_DELAY    = 3'd6;
  localparam logic [2:0] REG_LONG_PRESS    = 3'd7;

  // Hold mode codes; any other code means no hold behaviour.
  localparam logic [1:0] HOLD_NONE   = 2'd0;
  localparam logic [1:0] HOLD_REPEAT = 2'd1;
  localparam logic [1:0] HOLD_LONG   = 2'd2;
  localparam logic [1:0] HOLD_SPARE  = 2'd3;

  // Reset values of the limit registers.
  localparam logic [TICK_W-1:0] DEBOUNCE_RST      = 16'd2;
  localparam logic [TICK_W-1:0] REPEAT_DELAY_RST  = 16'd50;
  localparam logic [TICK_W-1:0] REPEAT_PERIOD_RST = 16'd5;
  localparam logic [TICK_W-1:0] FAST_DELAY_RST    = 16'd150;
  localparam logic [TICK_W-1:0] LONG_PRESS_RST    = 16'd100;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_RELEASED = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_PRESS  = 2'd1,
    EV_REPEAT = 2'd2,
    EV_LONG   = 2'd3
  } event_e;

  typedef struct packed {
    logic              active_level;
    logic [1:0]        hold_sel;
    logic              click_on_release;
    logic [TICK_W-1:0] debounce_ticks;
    logic [TICK_W-1:0] repeat_delay_ticks;
    logic [TICK_W-1:0] repeat_period_ticks;
    logic [TICK_W-1:0] fast_delay_ticks;
    logic [TICK_W-1:0] long_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic   click;
    logic   repeat_ev;
    logic   long_ev;
    logic   fast;
    phase_e phase;
    event_e last;
  } res_t;

endpackage

[rtl/bdd_cfg.sv]
module bdd_cfg
  import bdd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [4:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output cfg_t        cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign idx   = paddr_i[4:2];
  assign wr_en = psel_i && penable_i && pwrite_i;

  // Register writes in the access phase of a transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_level        <= 1'b0;
      cfg_q.hold_sel            <= HOLD_NONE;
      cfg_q.click_on_release    <= 1'b0;
      cfg_q.debounce_ticks      <= DEBOUNCE_RST;
      cfg_q.repeat_delay_ticks  <= REPEAT_DELAY_RST;
      cfg_q.repeat_period_ticks <= REPEAT_PERIOD_RST;
      cfg_q.fast_delay_ticks    <= FAST_DELAY_RST;
      cfg_q.long_press_ticks    <= LONG_PRESS_RST;
    end else if (wr_en) begin
      case (idx)
        REG_ACTIVE_LEVEL:  cfg_q.active_level        <= pwdata_i[0];
        REG_HOLD_MODE:     cfg_q.hold_sel            <= pwdata_i[1:0];
        REG_CLICK_ON_REL:  cfg_q.click_on_release    <= pwdata_i[0];
        REG_DEBOUNCE:      cfg_q.debounce_ticks      <= pwdata_i[TICK_W-1:0];
        REG_REPEAT_DELAY:  cfg_q.repeat_delay_ticks  <= pwdata_i[TICK_W-1:0];
        REG_REPEAT_PERIOD: cfg_q.repeat_period_ticks <= pwdata_i[TICK_W-1:0];
        REG_FAST_DELAY:    cfg_q.fast_delay_ticks    <= pwdata_i[TICK_W-1:0];
        REG_LONG_PRESS:    cfg_q.long_press_ticks    <= pwdata_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (idx)
      REG_ACTIVE_LEVEL:  prdata_o = {31'd0, cfg_q.active_level};
      REG_HOLD_MODE:     prdata_o = {30'd0, cfg_q.hold_sel};
      REG_CLICK_ON_REL:  prdata_o = {31'd0, cfg_q.click_on_release};
      REG_DEBOUNCE:      prdata_o = {16'd0, cfg_q.debounce_ticks};
      REG_REPEAT_DELAY:  prdata_o = {16'd0, cfg_q.repeat_delay_ticks};
      REG_REPEAT_PERIOD: prdata_o = {16'd0, cfg_q.repeat_period_ticks};
      REG_FAST_DELAY:    prdata_o = {16'd0, cfg_q.fast_delay_ticks};
      REG_LONG_PRESS:    prdata_o = {16'd0, cfg_q.long_press_ticks};
      default:           prdata_o = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/bdd_core.sv]
module bdd_core
  import bdd_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  logic level_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  localparam int unsigned CmpW = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  // Increment that sticks at the top of the counter range.
  function automatic cnt_t sat_inc(input cnt_t v);
    return (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

  // True once a count has reached its limit.
  function automatic logic reached(input cnt_t c, input logic [TICK_W-1:0] lim);
    return CmpW'(c) >= CmpW'(lim);
  endfunction

  logic   stable_q, stable_d;
  cnt_t   deb_q, deb_d;
  phase_e phase_q, phase_d;
  event_e rec_q, rec_d;
  cnt_t   rdc_q, rdc_d;
  cnt_t   rpc_q, rpc_d;
  cnt_t   fc_q, fc_d;
  cnt_t   lc_q, lc_d;
  logic   lf_q, lf_d;
  logic   ff_q, ff_d;

  // State update once per transfer into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b1;
      deb_q    <= '0;
      phase_q  <= PH_IDLE;
      rec_q    <= EV_NONE;
      rdc_q    <= '0;
      rpc_q    <= '0;
      fc_q     <= '0;
      lc_q     <= '0;
      lf_q     <= 1'b0;
      ff_q     <= 1'b0;
    end else if (step_i) begin
      stable_q <= stable_d;
      deb_q    <= deb_d;
      phase_q  <= phase_d;
      rec_q    <= rec_d;
      rdc_q    <= rdc_d;
      rpc_q    <= rpc_d;
      fc_q     <= fc_d;
      lc_q     <= lc_d;
      lf_q     <= lf_d;
      ff_q     <= ff_d;
    end
  end

  // One tick: debounce first, then the hold behaviour of the new phase.
  always_comb begin
    cnt_t   deb_inc;
    cnt_t   rdc_inc;
    cnt_t   rpc_inc;
    cnt_t   fc_inc;
    cnt_t   lc_inc;
    phase_e ph_mid;
    logic   click;
    logic   rep;
    logic   lng;

    stable_d = stable_q;
    deb_d    = deb_q;
    ph_mid   = phase_q;
    phase_d  = phase_q;
    rec_d    = rec_q;
    rdc_d    = rdc_q;
    rpc_d    = rpc_q;
    fc_d     = fc_q;
    lc_d     = lc_q;
    lf_d     = lf_q;
    ff_d     = ff_q;
    click    = 1'b0;
    rep      = 1'b0;
    lng      = 1'b0;
    deb_inc  = sat_inc(deb_q);
    rdc_inc  = sat_inc(rdc_q);
    rpc_inc  = sat_inc(rpc_q);
    fc_inc   = sat_inc(fc_q);
    lc_inc   = sat_inc(lc_q);

    // Debounce: differing samples add up and are never cleared by a bounce.
    if (level_i != stable_q) begin
      if (reached(deb_inc, cfg_i.debounce_ticks)) begin
        stable_d = level_i;
        deb_d    = '0;
        if (level_i == cfg_i.active_level) begin
          ph_mid = PH_PRESSED;
          rec_d  = EV_PRESS;
          click  = !cfg_i.click_on_release;
        end else begin
          ph_mid = PH_RELEASED;
        end
      end else begin
        deb_d = deb_inc;
      end
    end
    phase_d = ph_mid;

    // Hold behaviour while pressed, and the one-tick release phase.
    if (ph_mid == PH_PRESSED) begin
      if (stable_d == cfg_i.active_level) begin
        case (cfg_i.hold_sel)
          HOLD_REPEAT: begin
            if (reached(rdc_inc, cfg_i.repeat_delay_ticks)) begin
              rdc_d = COUNT_WIDTH'(cfg_i.repeat_delay_ticks);
              if (reached(rpc_inc, cfg_i.repeat_period_ticks)) begin
                rpc_d = '0;
                rec_d = EV_REPEAT;
                rep   = 1'b1;
              end else begin
                rpc_d = rpc_inc;
              end
              if (reached(fc_inc, cfg_i.fast_delay_ticks)) begin
                fc_d = COUNT_WIDTH'(cfg_i.fast_delay_ticks);
                ff_d = 1'b1;
              end else begin
                fc_d = fc_inc;
              end
            end else begin
              rdc_d = rdc_inc;
            end
          end
          HOLD_LONG: begin
            if (reached(lc_inc, cfg_i.long_press_ticks)) begin
              lc_d = COUNT_WIDTH'(cfg_i.long_press_ticks);
              if (!lf_q) begin
                lf_d  = 1'b1;
                rec_d = EV_LONG;
                lng   = 1'b1;
              end
            end else begin
              lc_d = lc_inc;
            end
          end
          default: ;
        endcase
      end
    end else if (ph_mid == PH_RELEASED) begin
      click   = cfg_i.click_on_release && !lf_q;
      rdc_d   = '0;
      rpc_d   = '0;
      fc_d    = '0;
      lc_d    = '0;
      lf_d    = 1'b0;
      ff_d    = 1'b0;
      phase_d = PH_IDLE;
    end

    res_o.click     = click;
    res_o.repeat_ev = rep;
    res_o.long_ev   = lng;
    res_o.fast      = ff_d;
    res_o.phase     = ph_mid;
    res_o.last      = rec_d;
  end

endmodule

[rtl/button_debounce_event_detector.sv]
// Button debounce and event detector.
// The input channel (in_valid_i / in_ready_o) carries one sampled pin level
// per tick in pin_level_i. The output channel (out_valid_o / out_ready_i)
// returns exactly one result per tick: click, repeat and long-press events,
// the fast-repeat flag, the button phase and the latest recorded event.
// A sample is held in an input register, processed by the per-tick logic
// and written to the result register once the output can take it; the
// result is offered from that register. One sample is taken every cycle
// while the receiver does not stall. When the receiver stalls, the result
// register holds its value and the input register still takes one more
// sample; in_ready_o falls only when both registers are full. Limits and
// modes are set through the APB port, word i at byte address 4*i, by the
// user only while the block is idle; the block does not enforce it. Reset
// brings every config register to its documented value, the stable level
// to released-high and all counters to zero.
`include "assert_macros.svh"

module button_debounce_event_detector
  import bdd_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        pin_level_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        click_event_o,
  output logic        repeat_event_o,
  output logic        long_event_o,
  output logic        fast_repeat_o,
  output logic [1:0]  button_phase_o,
  output logic [1:0]  last_event_o
);

  cfg_t cfg;
  res_t res;
  res_t res_q;
  logic s1_valid_q, s1_valid_d;
  logic s1_level_q;
  logic out_valid_q, out_valid_d;
  logic adv;
  logic in_xfer;
  logic rel_tick;

  assign pready = 1'b1;

  bdd_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  // Handshake control of the two pipeline registers.
  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_level_q <= pin_level_i;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  bdd_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (adv),
    .level_i (s1_level_q),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  assign out_valid_o    = out_valid_q;
  assign click_event_o  = res_q.click;
  assign repeat_event_o = res_q.repeat_ev;
  assign long_event_o   = res_q.long_ev;
  assign fast_repeat_o  = res_q.fast;
  assign button_phase_o = res_q.phase;
  assign last_event_o   = res_q.last;

  // A valid result that reports the release tick.
  assign rel_tick = out_valid_o && (button_phase_o == PH_RELEASED);

  // Checks on the pipeline and on the event logic.
  `BDD_ASSERT_IMP(a_stall_full, !in_ready_o, out_valid_o && !out_ready_i, "stall while not full")
  `BDD_ASSERT_IMP(a_hold_excl, out_valid_o, !(repeat_event_o && long_event_o), "two hold events")
  `BDD_ASSERT_IMP(a_rel_quiet, rel_tick, !repeat_event_o && !long_event_o, "event on release")

endmodule
